[sv/svc_pkg.sv]
// sector visibility check: shared widths, pipeline lane types and the arctangent table
// used by every module and by the channel interfaces of the core
`default_nettype none

package svc_pkg;

  localparam int ARCTAN_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam int POS_W       = 16;
  localparam int ANG_W       = 16;
  localparam int DIFF_W      = POS_W + 1;
  localparam int SQ_W        = 2 * POS_W;
  localparam int PRESCALE_SH = 24;
  localparam int XY_W        = DIFF_W + PRESCALE_SH + 3;
  localparam int ACC_W       = 32;

  localparam logic [ANG_W-1:0] QUARTER_TURN       = 16'h4000;
  localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 16'hC000;
  localparam logic [ACC_W-1:0] ROUND_HALF         = 32'h0000_8000;

  typedef struct packed {
    logic             near;
    logic             coincident;
    logic             dy_zero;
    logic             dx_pos;
    logic             dy_neg;
    logic [ANG_W-1:0] heading;
    logic [ANG_W-1:0] cone;
  } ctx_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ACC_W-1:0]       acc;
    ctx_t                   ctx;
  } lane_t;

  // atan(2^-k) as a 32-bit binary angle
  function automatic logic [ACC_W-1:0] atan_entry(input int unsigned k);
    logic [ACC_W-1:0] v;
    unique case (k)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/svc_req_if.sv]
// request channel of the sector visibility check: valid/ready plus pose fields
// depends on svc_pkg for field widths
`default_nettype none

interface svc_req_if;
  logic                            valid;
  logic                            ready;
  logic signed [svc_pkg::POS_W-1:0] receiver_x;
  logic signed [svc_pkg::POS_W-1:0] receiver_y;
  logic signed [svc_pkg::POS_W-1:0] source_x;
  logic signed [svc_pkg::POS_W-1:0] source_y;
  logic [svc_pkg::ANG_W-1:0]        source_heading;
  logic [svc_pkg::ANG_W-1:0]        cone_width;
  logic [svc_pkg::POS_W-1:0]        reach;

  modport source (
    output valid, receiver_x, receiver_y, source_x, source_y,
           source_heading, cone_width, reach,
    input  ready
  );

  modport sink (
    input  valid, receiver_x, receiver_y, source_x, source_y,
           source_heading, cone_width, reach,
    output ready
  );
endinterface

`default_nettype wire

[sv/svc_rsp_if.sv]
// result channel of the sector visibility check: valid/ready plus verdict and bearing
// depends on svc_pkg for field widths
`default_nettype none

interface svc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      visible;
  logic                      near_enough;
  logic [svc_pkg::ANG_W-1:0] bearing;

  modport source (
    output valid, visible, near_enough, bearing,
    input  ready
  );

  modport sink (
    input  valid, visible, near_enough, bearing,
    output ready
  );
endinterface

`default_nettype wire

[sv/svc_front.sv]
// front end: offsets, squared distance against squared reach, cordic start vector
// three stages with their own valid bits; depends on svc_pkg and svc_req_if
`default_nettype none

module svc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  svc_req_if.sink             req,
  output      logic           next_valid,
  input  wire logic           next_ready,
  output      svc_pkg::lane_t next_lane
);

  localparam int DIFF_W = svc_pkg::DIFF_W;
  localparam int SQ_W   = svc_pkg::SQ_W;
  localparam int EXT_W  = svc_pkg::XY_W - DIFF_W - svc_pkg::PRESCALE_SH;

  // stage 1
  logic                               v1;
  logic signed [DIFF_W-1:0]           dx1;
  logic signed [DIFF_W-1:0]           dy1;
  logic [svc_pkg::ANG_W-1:0]          heading1;
  logic [svc_pkg::ANG_W-1:0]          cone1;
  logic [svc_pkg::POS_W-1:0]          reach1;
  // stage 2
  logic                               v2;
  logic [SQ_W-1:0]                    dx2;
  logic [SQ_W-1:0]                    dy2;
  logic [SQ_W-1:0]                    r2;
  svc_pkg::lane_t                     lane2;
  // stage 3
  logic                               v3;
  svc_pkg::lane_t                     lane3;

  logic                               rdy1;
  logic                               rdy2;
  logic                               rdy3;

  logic signed [DIFF_W-1:0]           dx_next;
  logic signed [DIFF_W-1:0]           dy_next;
  logic signed [2*DIFF_W-1:0]         dx_sq;
  logic signed [2*DIFF_W-1:0]         dy_sq;
  logic signed [DIFF_W-1:0]           abs_dy;
  logic signed [DIFF_W-1:0]           y_start;
  svc_pkg::lane_t                     lane2_next;
  svc_pkg::lane_t                     lane3_next;
  logic                               near_next;

  assign rdy3      = !v3 || next_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1;

  assign dx_next = DIFF_W'(req.receiver_x) - DIFF_W'(req.source_x);
  assign dy_next = DIFF_W'(req.receiver_y) - DIFF_W'(req.source_y);

  assign dx_sq   = dx1 * dx1;
  assign dy_sq   = dy1 * dy1;
  assign abs_dy  = dy1[DIFF_W-1] ? -dy1 : dy1;
  assign y_start = dy1[DIFF_W-1] ? -dx1 : dx1;

  always_comb begin
    lane2_next.x   = {{EXT_W{abs_dy[DIFF_W-1]}}, abs_dy, {svc_pkg::PRESCALE_SH{1'b0}}};
    lane2_next.y   = {{EXT_W{y_start[DIFF_W-1]}}, y_start, {svc_pkg::PRESCALE_SH{1'b0}}};
    lane2_next.acc = '0;
    lane2_next.ctx.near       = 1'b0;
    lane2_next.ctx.coincident = (dx1 == '0) && (dy1 == '0);
    lane2_next.ctx.dy_zero    = (dy1 == '0);
    lane2_next.ctx.dx_pos     = !dx1[DIFF_W-1] && (dx1 != '0);
    lane2_next.ctx.dy_neg     = dy1[DIFF_W-1];
    lane2_next.ctx.heading    = heading1;
    lane2_next.ctx.cone       = cone1;
  end

  assign near_next = ({1'b0, dx2} + {1'b0, dy2}) <= {1'b0, r2};

  always_comb begin
    lane3_next          = lane2;
    lane3_next.ctx.near = near_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= req.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && req.valid) begin
      dx1      <= dx_next;
      dy1      <= dy_next;
      heading1 <= req.source_heading;
      cone1    <= req.cone_width;
      reach1   <= req.reach;
    end
    if (rdy2 && v1) begin
      dx2   <= dx_sq[SQ_W-1:0];
      dy2   <= dy_sq[SQ_W-1:0];
      r2    <= SQ_W'(reach1) * SQ_W'(reach1);
      lane2 <= lane2_next;
    end
    if (rdy3 && v2) begin
      lane3 <= lane3_next;
    end
  end

  assign next_valid = v3;
  assign next_lane  = lane3;

endmodule

`default_nettype wire

[sv/svc_cell.sv]
// one vectoring cordic step: rotates the vector toward the x axis and sums the angle
// a chain of these forms the arctangent; depends on svc_pkg
`default_nettype none

module svc_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           prev_valid,
  output      logic           prev_ready,
  input  wire svc_pkg::lane_t prev_lane,
  output      logic           next_valid,
  input  wire logic           next_ready,
  output      svc_pkg::lane_t next_lane
);

  localparam logic [svc_pkg::ACC_W-1:0] ANGLE = svc_pkg::atan_entry(STEP);

  logic                             valid;
  svc_pkg::lane_t                   lane;
  svc_pkg::lane_t                   lane_next;
  logic signed [svc_pkg::XY_W-1:0]  xs;
  logic signed [svc_pkg::XY_W-1:0]  ys;

  assign prev_ready = !valid || next_ready;

  assign xs = prev_lane.x >>> STEP;
  assign ys = prev_lane.y >>> STEP;

  always_comb begin
    lane_next = prev_lane;
    if (!prev_lane.y[svc_pkg::XY_W-1]) begin
      lane_next.x   = prev_lane.x + ys;
      lane_next.y   = prev_lane.y - xs;
      lane_next.acc = prev_lane.acc + ANGLE;
    end else begin
      lane_next.x   = prev_lane.x - ys;
      lane_next.y   = prev_lane.y + xs;
      lane_next.acc = prev_lane.acc - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (prev_ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_ready && prev_valid) begin
      lane <= lane_next;
    end
  end

  assign next_valid = valid;
  assign next_lane  = lane;

endmodule

`default_nettype wire

[sv/svc_back.sv]
// back end: rounds the angle, applies axis cases and quadrant offset, cone test
// last stage is the output register; depends on svc_pkg and svc_rsp_if
`default_nettype none

module svc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           prev_valid,
  output      logic           prev_ready,
  input  wire svc_pkg::lane_t prev_lane,
  svc_rsp_if.source           rsp
);

  localparam int ANG_W = svc_pkg::ANG_W;
  localparam int ACC_W = svc_pkg::ACC_W;

  logic              vb1;
  logic [ANG_W-1:0]  bearing1;
  logic              near1;
  logic              coincident1;
  logic [ANG_W-1:0]  heading1;
  logic [ANG_W-1:0]  cone1;

  logic              vb2;
  logic              visible2;
  logic              near2;
  logic [ANG_W-1:0]  bearing2;

  logic              rdy1;
  logic              rdy2;

  logic [ACC_W-1:0]  rounded;
  logic [ANG_W-1:0]  angle;
  logic [ANG_W-1:0]  bearing_next;
  logic [ANG_W-1:0]  diff;
  logic [ANG_W-1:0]  mag;
  logic              in_cone;

  assign rdy2       = !vb2 || rsp.ready;
  assign rdy1       = !vb1 || rdy2;
  assign prev_ready = rdy1;

  assign rounded = prev_lane.acc + svc_pkg::ROUND_HALF;

  always_comb begin
    priority if (prev_lane.ctx.dy_zero) begin
      angle = prev_lane.ctx.dx_pos ? svc_pkg::QUARTER_TURN : svc_pkg::THREE_QUARTER_TURN;
    end else begin
      angle = rounded[ACC_W-1 -: ANG_W];
    end
    priority if (prev_lane.ctx.coincident) begin
      bearing_next = '0;
    end else begin
      bearing_next = angle + (prev_lane.ctx.dy_neg ? svc_pkg::QUARTER_TURN
                                                   : svc_pkg::THREE_QUARTER_TURN);
    end
  end

  assign diff    = bearing1 - heading1;
  assign mag     = diff[ANG_W-1] ? -diff : diff;
  assign in_cone = {mag, 1'b0} < {1'b0, cone1};

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
    end else begin
      if (rdy1) begin
        vb1 <= prev_valid;
      end
      if (rdy2) begin
        vb2 <= vb1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && prev_valid) begin
      bearing1    <= bearing_next;
      near1       <= prev_lane.ctx.near;
      coincident1 <= prev_lane.ctx.coincident;
      heading1    <= prev_lane.ctx.heading;
      cone1       <= prev_lane.ctx.cone;
    end
    if (rdy2 && vb1) begin
      visible2 <= near1 && !coincident1 && in_cone;
      near2    <= near1;
      bearing2 <= bearing1;
    end
  end

  assign rsp.valid       = vb2;
  assign rsp.visible     = visible2;
  assign rsp.near_enough = near2;
  assign rsp.bearing     = bearing2;

endmodule

`default_nettype wire

[sv/sector_visibility_check_core.sv]
// sector visibility check core: front end, chain of cordic cells, back end
// depends on svc_pkg, svc_req_if, svc_rsp_if, svc_front, svc_cell, svc_back
//
//  channel  dir  handshake    payload
//  req      in   valid/ready  receiver_x/y, source_x/y, source_heading, cone_width, reach
//  rsp      out  valid/ready  visible, near_enough, bearing
//
// one request per cycle unless rsp stalls; path: front end, cordic cells, back end
// every stage has its own valid bit, so bubbles close up while rsp is stalled
// rst is synchronous and clears only the valid bits; no state is kept between requests
`default_nettype none

module sector_visibility_check_core #(
  parameter int ARCTAN_STEPS = svc_pkg::ARCTAN_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  svc_req_if.sink   req,
  svc_rsp_if.source rsp
);

  logic           valid [ARCTAN_STEPS+1];
  logic           ready [ARCTAN_STEPS+1];
  svc_pkg::lane_t lane  [ARCTAN_STEPS+1];

  svc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .next_valid (valid[0]),
    .next_ready (ready[0]),
    .next_lane  (lane[0])
  );

  for (genvar g = 0; g < ARCTAN_STEPS; g++) begin : g_cell
    svc_cell #(
      .STEP (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .prev_valid (valid[g]),
      .prev_ready (ready[g]),
      .prev_lane  (lane[g]),
      .next_valid (valid[g+1]),
      .next_ready (ready[g+1]),
      .next_lane  (lane[g+1])
    );
  end

  svc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (valid[ARCTAN_STEPS]),
    .prev_ready (ready[ARCTAN_STEPS]),
    .prev_lane  (lane[ARCTAN_STEPS]),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire
